// ===== design/dad_pkg.sv =====
// Shared types, codes and weekday helpers for the daylight saving decider.
package dad_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int CENT_W  = 8;
   localparam int YRC_W   = 7;
   localparam int SUM_W   = 10;
   localparam int PROD_W  = 27;

   // year / 100 == (year * RECIP_100) >> RECIP_SHIFT for every 14-bit year
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

   // Zeller month/day offsets mod 7 for the switch dates
   localparam logic [2:0] OFS_MAR_1  = 3'd4;
   localparam logic [2:0] OFS_MAR_31 = 3'd6;
   localparam logic [2:0] OFS_APR_1  = 3'd0;
   localparam logic [2:0] OFS_OCT_1  = 3'd1;
   localparam logic [2:0] OFS_OCT_31 = 3'd3;
   localparam logic [2:0] OFS_NOV_1  = 3'd4;

   typedef enum logic [1:0] {
      RULE_NONE = 2'd0,
      RULE_US   = 2'd1,
      RULE_EU   = 2'd2,
      RULE_AU   = 2'd3
   } rule_type;

   typedef struct packed {
      logic               valid;
      logic [CENT_W-1:0]  cent;
      logic [YRC_W-1:0]   yrc;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } split_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         ykey;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } week_type;

   function automatic logic [2:0] mod7(input logic [SUM_W-1:0] x);
      logic [4:0] s;
      logic [3:0] t;
      s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
      t = 4'(s[2:0]) + 4'(s[4:3]);
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

   // weekday, 0 = Sunday
   function automatic logic [2:0] weekday(input logic [2:0] ykey, input logic [2:0] ofs);
      logic [3:0] h;
      h = 4'(ykey) + 4'(ofs);
      if (h >= 4'd7) begin
         h = h - 4'd7;
      end
      h = h + 4'd6;
      if (h >= 4'd7) begin
         h = h - 4'd7;
      end
      return h[2:0];
   endfunction

   function automatic logic [DAY_W-1:0] first_sunday(input logic [2:0] wd);
      return (wd == 3'd0) ? 5'd1 : 5'd8 - 5'(wd);
   endfunction

   function automatic logic [DAY_W-1:0] last_sunday31(input logic [2:0] wd);
      return 5'd31 - 5'(wd);
   endfunction

endpackage

// ===== design/dst_active_decider_core.sv =====
// Accepts one date word per cycle while req_tready is high and answers
// whether daylight saving applies under the rule in the region register.
// The date passes a five-stage pipeline (reciprocal multiply by 1/100,
// century split, year key sum, mod 7 reduction, rule compare), each stage
// registered, and a new word can enter every cycle unless back-pressured.
// Each stage holds its word while the next is full,
// so a back-pressured result only stops words that would collide with it.
// Write the region register only while no words are in flight.
module dst_active_decider_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // year[13:0], month[17:14], day[22:18], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // saving_active[0], zero
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata   // region_rule
);
   import dad_pkg::*;

   rule_type  rule_ff, rule_in;
   split_type split;
   week_type  week;
   logic      split_ready, week_ready;
   logic      active;

   assign rule_in = csr_we ? rule_type'(csr_wdata) : rule_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RULE_NONE;
      end else begin
         rule_ff <= rule_in;
      end
   end

   dad_year_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_year   (req_tdata[13:0]),
      .in_month  (req_tdata[17:14]),
      .in_day    (req_tdata[22:18]),
      .out       (split),
      .out_ready (split_ready)
   );

   dad_weekday u_week (
      .clock     (clock),
      .reset     (reset),
      .in        (split),
      .in_ready  (split_ready),
      .out       (week),
      .out_ready (week_ready)
   );

   dad_rule_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .rule       (rule_ff),
      .in         (week),
      .in_ready   (week_ready),
      .out_valid  (rsp_tvalid),
      .out_active (active),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {7'd0, active};

endmodule

// ===== design/dad_year_split.sv =====
// Splits the year into century and year of century by reciprocal multiply.
module dad_year_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dad_pkg::YEAR_W-1:0]  in_year,
   input  logic [dad_pkg::MONTH_W-1:0] in_month,
   input  logic [dad_pkg::DAY_W-1:0]   in_day,
   output dad_pkg::split_type          out,
   input  logic                        out_ready
);
   import dad_pkg::*;

   logic               a_valid_ff, a_valid_in;
   logic [YEAR_W-1:0]  a_year_ff;
   logic [PROD_W-1:0]  a_prod_ff;
   logic [MONTH_W-1:0] a_month_ff;
   logic [DAY_W-1:0]   a_day_ff;
   logic               a_ready;

   split_type          b_ff, b_in;
   logic               b_ready;
   logic [CENT_W-1:0]  cent;
   logic [YEAR_W-1:0]  yrc_full;

   assign b_ready  = !b_ff.valid || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;
   assign a_valid_in = a_ready ? in_valid : a_valid_ff;

   assign cent     = a_prod_ff[RECIP_SHIFT +: CENT_W];
   assign yrc_full = a_year_ff - YEAR_W'(cent) * YEAR_W'(100);

   always_comb begin
      b_in = b_ff;
      if (b_ready) begin
         b_in.valid = a_valid_ff;
         b_in.cent  = cent;
         b_in.yrc   = yrc_full[YRC_W-1:0];
         b_in.month = a_month_ff;
         b_in.day   = a_day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_ff.valid <= b_in.valid;
      end
      if (a_ready && in_valid) begin
         a_year_ff  <= in_year;
         a_prod_ff  <= PROD_W'(in_year) * PROD_W'(RECIP_100);
         a_month_ff <= in_month;
         a_day_ff   <= in_day;
      end
      b_ff.cent  <= b_in.cent;
      b_ff.yrc   <= b_in.yrc;
      b_ff.month <= b_in.month;
      b_ff.day   <= b_in.day;
   end

   assign out = b_ff;

endmodule

// ===== design/dad_weekday.sv =====
// Reduces century and year of century to the Zeller year key mod 7.
module dad_weekday (
   input  logic               clock,
   input  logic               reset,
   input  dad_pkg::split_type in,
   output logic               in_ready,
   output dad_pkg::week_type  out,
   input  logic               out_ready
);
   import dad_pkg::*;

   logic               c_valid_ff;
   logic [SUM_W-1:0]   c_sum_ff;
   logic [MONTH_W-1:0] c_month_ff;
   logic [DAY_W-1:0]   c_day_ff;
   logic               c_ready;
   logic [SUM_W-1:0]   sum;

   week_type           d_ff, d_in;
   logic               d_ready;

   assign d_ready  = !d_ff.valid || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // k + k/4 + j/4 + 5j
   assign sum = SUM_W'(in.yrc) + SUM_W'(in.yrc >> 2) + SUM_W'(in.cent >> 2)
              + (SUM_W'(in.cent) << 2) + SUM_W'(in.cent);

   always_comb begin
      d_in = d_ff;
      if (d_ready) begin
         d_in.valid = c_valid_ff;
         d_in.ykey  = mod7(c_sum_ff);
         d_in.month = c_month_ff;
         d_in.day   = c_day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_ff.valid <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= in.valid;
         end
         d_ff.valid <= d_in.valid;
      end
      if (c_ready && in.valid) begin
         c_sum_ff   <= sum;
         c_month_ff <= in.month;
         c_day_ff   <= in.day;
      end
      d_ff.ykey  <= d_in.ykey;
      d_ff.month <= d_in.month;
      d_ff.day   <= d_in.day;
   end

   assign out = d_ff;

endmodule

// ===== design/dad_rule_eval.sv =====
// Applies the regional rule to the switch Sundays and holds the result word.
module dad_rule_eval (
   input  logic              clock,
   input  logic              reset,
   input  dad_pkg::rule_type rule,
   input  dad_pkg::week_type in,
   output logic              in_ready,
   output logic              out_valid,
   output logic              out_active,
   input  logic              out_ready
);
   import dad_pkg::*;

   logic           e_valid_ff;
   logic           e_active_ff;
   logic           e_ready;
   logic           active;
   logic [DAY_W-1:0] us_on, us_off, eu_on, eu_off, au_on, au_off;

   assign e_ready  = !e_valid_ff || out_ready;
   assign in_ready = e_ready;

   assign us_on  = first_sunday(weekday(in.ykey, OFS_MAR_1)) + 5'd7;
   assign us_off = first_sunday(weekday(in.ykey, OFS_NOV_1));
   assign eu_on  = last_sunday31(weekday(in.ykey, OFS_MAR_31));
   assign eu_off = last_sunday31(weekday(in.ykey, OFS_OCT_31));
   assign au_on  = first_sunday(weekday(in.ykey, OFS_OCT_1));
   assign au_off = first_sunday(weekday(in.ykey, OFS_APR_1));

   always_comb begin
      active = 1'b0;
      unique case (rule)
         RULE_US: begin
            if (in.month == MONTH_MAR) begin
               active = in.day >= us_on;
            end else if (in.month == MONTH_NOV) begin
               active = in.day < us_off;
            end else begin
               active = (in.month > MONTH_MAR) && (in.month < MONTH_NOV);
            end
         end
         RULE_EU: begin
            if (in.month == MONTH_MAR) begin
               active = in.day >= eu_on;
            end else if (in.month == MONTH_OCT) begin
               active = in.day < eu_off;
            end else begin
               active = (in.month > MONTH_MAR) && (in.month < MONTH_OCT);
            end
         end
         RULE_AU: begin
            if (in.month == MONTH_OCT) begin
               active = in.day >= au_on;
            end else if (in.month == MONTH_APR) begin
               active = in.day < au_off;
            end else begin
               active = (in.month < MONTH_APR) || (in.month > MONTH_OCT);
            end
         end
         RULE_NONE: begin
            active = 1'b0;
         end
         default: begin
            active = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_ready) begin
         e_valid_ff <= in.valid;
      end
      if (e_ready && in.valid) begin
         e_active_ff <= active;
      end
   end

   assign out_valid  = e_valid_ff;
   assign out_active = e_active_ff;

endmodule

// ===== design/dad_checker.sv =====
// Port-level checks for the daylight saving decider, bound to the top level.
module dad_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [23:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       csr_we,
   input logic [1:0] csr_wdata
);
   import dad_pkg::*;

   logic [1:0] rule_ff;
   logic       in_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff    <= 2'd0;
         in_seen_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            rule_ff <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            in_seen_ff <= 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> in_seen_ff)
      else $error("result word without any accepted date");

   a_none_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rule_ff == RULE_NONE |-> !rsp_tdata[0])
      else $error("saving active with no rule");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding not zero");

endmodule

bind dst_active_decider_core dad_checker u_dad_checker (.*);

// ===== tb/sv/dst_active_decider_checker.sv =====
`timescale 1ns / 100ps
// Checker for the daylight saving decider: predicts each answer and compares it.
module dst_active_decider_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   output int          errors,
   output int          pending
);
   import dad_pkg::*;

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      rule_type           rule;
      logic               saving;
   } saving_due_type;

   rule_type       region_q;
   saving_due_type saving_due[$];

   // 0 = Sunday, Zeller with Gregorian centuries
   function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
      int unsigned k;
      int unsigned j;
      int unsigned h;
      k = y % 100;
      j = y / 100;
      h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      return (h + 6) % 7;
   endfunction

   function automatic int unsigned sunday_nth(int unsigned y, int unsigned m, int unsigned n);
      return 1 + (7 - day_of_week(y, m, 1)) % 7 + (n - 1) * 7;
   endfunction

   function automatic int unsigned sunday_last31(int unsigned y, int unsigned m);
      return 31 - day_of_week(y, m, 31);
   endfunction

   function automatic logic dst_in_force(rule_type rule, int unsigned y, int unsigned m,
                                         int unsigned d);
      case (rule)
         RULE_US: begin
            if (m < MONTH_MAR || m > MONTH_NOV) return 1'b0;
            if (m > MONTH_MAR && m < MONTH_NOV) return 1'b1;
            if (m == MONTH_MAR) return d >= sunday_nth(y, MONTH_MAR, 2);
            return d < sunday_nth(y, MONTH_NOV, 1);
         end
         RULE_EU: begin
            if (m < MONTH_MAR || m > MONTH_OCT) return 1'b0;
            if (m > MONTH_MAR && m < MONTH_OCT) return 1'b1;
            if (m == MONTH_MAR) return d >= sunday_last31(y, MONTH_MAR);
            return d < sunday_last31(y, MONTH_OCT);
         end
         RULE_AU: begin
            if (m > MONTH_APR && m < MONTH_OCT) return 1'b0;
            if (m < MONTH_APR || m > MONTH_OCT) return 1'b1;
            if (m == MONTH_OCT) return d >= sunday_nth(y, MONTH_OCT, 1);
            return d < sunday_nth(y, MONTH_APR, 1);
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      saving_due_type due;
      if (reset) begin
         region_q <= RULE_NONE;
         saving_due.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         // answers first, so a word accepted this edge cannot match one leaving now
         if (rsp_tvalid && rsp_tready) begin
            if (saving_due.size() == 0) begin
               if (errors < 10)
                  $display("unexpected answer %0b at %0t", rsp_tdata[0], $realtime);
               errors <= errors + 1;
            end else begin
               due = saving_due.pop_front();
               if (rsp_tdata[0] !== due.saving) begin
                  if (errors < 10)
                     $display("mismatch: %0d-%0d-%0d rule %s expected %0b got %0b",
                              due.year, due.month, due.day, due.rule.name(),
                              due.saving, rsp_tdata[0]);
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            due.year   = req_tdata[13:0];
            due.month  = req_tdata[17:14];
            due.day    = req_tdata[22:18];
            due.rule   = region_q;
            due.saving = dst_in_force(region_q, due.year, due.month, due.day);
            saving_due.push_back(due);
         end
         if (csr_we)
            region_q <= rule_type'(csr_wdata);
         pending <= saving_due.size();
      end
   end

endmodule

// ===== tb/sv/dst_active_decider_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the daylight saving decider: stimulus, idling and verdict.
module dst_active_decider_core_tb;
   import dad_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 180;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // year[13:0], month[17:14], day[22:18], zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // saving_active[0], zero
   logic        csr_we;
   logic [1:0]  csr_wdata;   // region_rule
   int          errors;
   int          pending;
   int          idle_cycles;
   int          stall_left;
   bit          steady;

   dst_active_decider_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   dst_active_decider_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
      int  gap;
      bit  taken;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, d[4:0], m[3:0], y[13:0]};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic set_region(input rule_type rule);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rule;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_random_date();
      int unsigned y;
      int unsigned m;
      int unsigned switch_months[4];
      switch_months = '{MONTH_MAR, MONTH_APR, MONTH_OCT, MONTH_NOV};
      y = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 9999) : $urandom_range(0, 16383);
      m = ($urandom_range(0, 99) < 70) ? switch_months[$urandom_range(0, 3)]
                                       : $urandom_range(0, 15);
      send_date(y, m, $urandom_range(0, 31));
   endtask

   initial begin
      rule_type phase_rules[8];
      phase_rules = '{RULE_US, RULE_EU, RULE_AU, RULE_NONE,
                      RULE_AU, RULE_US, RULE_EU, RULE_AU};
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = RULE_NONE;
      stall_left = 0;
      steady     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the region: never in force
      send_date(2024, 7, 4);
      send_date(16383, 15, 31);
      send_date(0, 0, 0);

      set_region(RULE_US);
      send_date(2024, 3, 10);
      send_date(2024, 3, 9);
      send_date(2024, 11, 3);
      send_date(2024, 11, 2);
      send_date(0, 0, 0);
      send_date(16383, 15, 31);
      send_date(9999, 12, 31);
      send_date(1, 1, 1);

      set_region(RULE_EU);
      send_date(2024, 3, 31);
      send_date(2024, 3, 30);
      send_date(2024, 10, 27);
      send_date(2024, 10, 26);
      send_date(2024, 13, 5);
      send_date(0, 3, 31);
      send_date(16383, 10, 0);

      set_region(RULE_AU);
      send_date(2024, 10, 6);
      send_date(2024, 10, 5);
      send_date(2024, 4, 7);
      send_date(2024, 4, 6);
      send_date(2024, 0, 15);
      send_date(2024, 14, 15);
      send_date(2024, 7, 15);

      foreach (phase_rules[p]) begin
         set_region(phase_rules[p]);
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2)
               wait_drained();
            send_random_date();
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
